// ===== design/iwc_pkg.sv =====
`timescale 1ns / 1ps

package iwc_pkg;

    // Kernel geometry
    localparam int RADIUS     = 1;
    localparam int KSIZE      = 2 * RADIUS + 1;
    localparam int KAREA      = KSIZE * KSIZE;
    localparam int KIDX_W     = $clog2(KAREA);

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);

    // Field widths
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int CIDX_W     = 6;
    localparam int PROD_W     = PIX_W + COEF_W + 1;
    localparam int ACC_W      = 48;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;

    // Stream packing
    localparam int IN_FIELDS_W  = CIDX_W + COEF_W + PIX_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ACC_W + 2 * POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Line store word: one pixel per buffered row, slot 0 = previous row
    localparam int LB_W = PIX_W * (KSIZE - 1);

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Item kinds carried in tuser
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic prod_en;   // load product registers
        logic sum_en;    // load the sum register
    } t_mac_ctl;

endpackage

// ===== design/iwc_ram.sv =====
`timescale 1ns / 1ps

module iwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/iwc_mac.sv =====
`timescale 1ns / 1ps

module iwc_mac import iwc_pkg::*; (
    input  logic                   i_clk,
    input  t_mac_ctl               i_ctl,
    input  logic [KAREA-1:0][PIX_W-1:0]  i_win,
    input  logic [KAREA-1:0][COEF_W-1:0] i_coef,
    output t_acc                   o_sum
);

    logic signed [PROD_W-1:0] r_prod [KAREA];
    t_acc                     r_sum;
    t_acc                     n_sum;

    // unsigned pixel times signed coefficient, one multiplier per tap
    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            for (int k = 0; k < KAREA; k++) begin
                r_prod[k] <= PROD_W'($signed({1'b0, i_win[k]})) * PROD_W'($signed(i_coef[k]));
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < KAREA; k++) begin
            n_sum = n_sum + ACC_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== design/image_window_convolution.sv =====
`timescale 1ns / 1ps

// K x K window convolution (K = 2*RADIUS+1, 3 here) over one image channel
// streamed in raster order. An input transaction with tuser = 0 loads one
// kernel coefficient (signed Q4.12, row-major index, indices >= K*K are
// dropped); tuser = 1 delivers the next pixel (unsigned Q8.8). A result
// transaction comes out only for pixels whose K x K window lies wholly in
// the frame; it carries the exact 48-bit Q.20 sum of products, the window
// centre row and column, and tlast on the final result of a frame. One
// transaction is taken per clock while the result stream is not stalled.
// The four register stages are: line store read, window shift, K*K
// parallel multipliers, adder tree. The previous K-1 rows live in a
// single line store RAM (one word per column, K-1 pixels wide) so one
// read and one write per pixel suffice. Writing image_width or
// image_height restarts the frame at row 0, column 0; sizes are
// clamped to 1..1024. Coefficient loads take effect in stream order,
// also mid-frame.
module image_window_convolution import iwc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // coef_index, coef_value, pixel, zero pad
    input  logic                   i_s_axis_tuser,  // opcode
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // filtered, centre_row, centre_col, zero pad
    output logic                   o_m_axis_tlast   // frame_last
);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0]  r_image_width;
    logic [CFG_W-1:0]  r_image_height;
    logic [WDIM_W-1:0] w_eff;
    logic [HDIM_W-1:0] h_eff;

    always_comb begin
        if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WDIM_W'(MAX_WIDTH);
        end else if (r_image_width == '0) begin
            w_eff = WDIM_W'(1);
        end else begin
            w_eff = WDIM_W'(r_image_width);
        end
        if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HDIM_W'(MAX_HEIGHT);
        end else if (r_image_height == '0) begin
            h_eff = HDIM_W'(1);
        end else begin
            h_eff = HDIM_W'(r_image_height);
        end
    end

    // ---------------- input fields ----------------
    logic [CIDX_W-1:0] in_cidx;
    t_coef             in_cval;
    t_pix              in_pix;
    logic              in_is_pix;

    assign in_cidx   = i_s_axis_tdata[CIDX_W-1:0];
    assign in_cval   = i_s_axis_tdata[CIDX_W +: COEF_W];
    assign in_pix    = i_s_axis_tdata[CIDX_W + COEF_W +: PIX_W];
    assign in_is_pix = (i_s_axis_tuser == OP_PIXEL);

    // ---------------- stage handshake ----------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
    logic s_accept, s1_leave, s2_leave, s3_leave;

    assign out_rdy  = !r_out_valid || i_m_axis_tready;
    assign s3_rdy   = !r_s3_valid  || out_rdy;
    assign s2_rdy   = !r_s2_valid  || s3_rdy;
    assign s1_rdy   = !r_s1_valid  || s2_rdy;

    assign o_s_axis_tready = s1_rdy;
    assign s_accept = i_s_axis_tvalid && s1_rdy;
    assign s1_leave = r_s1_valid && s2_rdy;
    assign s2_leave = r_s2_valid && s3_rdy;
    assign s3_leave = r_s3_valid && out_rdy;

    // ---------------- raster position ----------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             col_end, row_end, win_fits;

    assign col_end  = (r_col == COL_W'(w_eff - WDIM_W'(1)));
    assign row_end  = (r_row == ROW_W'(h_eff - HDIM_W'(1)));
    // window fits once K-1 rows and columns precede the pixel
    assign win_fits = (32'(r_row) >= 32'(KSIZE - 1)) && (32'(r_col) >= 32'(KSIZE - 1));

    // ---------------- stage 1 registers (line store read in flight) ----
    logic              r_s1_is_pix;
    t_pix              r_s1_pix;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_fire;
    logic              r_s1_last;
    logic [POS_W-1:0]  r_s1_crow, r_s1_ccol;
    logic [CIDX_W-1:0] r_s1_cidx;
    t_coef             r_s1_cval;

    // ---------------- later stage metadata ----------------
    logic              r_s2_last, r_s3_last, r_out_last;
    logic [POS_W-1:0]  r_s2_crow, r_s2_ccol, r_s3_crow, r_s3_ccol, r_out_crow, r_out_ccol;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default:          ;
                endcase
                // any register write starts a new frame
                r_col <= '0;
                r_row <= '0;
            end else if (s_accept && in_is_pix) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            r_s1_valid  <= s_accept || (r_s1_valid && !s2_rdy);
            r_s2_valid  <= (s1_leave && r_s1_is_pix && r_s1_fire) || (r_s2_valid && !s3_rdy);
            r_s3_valid  <= s2_leave || (r_s3_valid && !out_rdy);
            r_out_valid <= s3_leave || (r_out_valid && !i_m_axis_tready);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_is_pix <= in_is_pix;
            r_s1_pix    <= in_pix;
            r_s1_col    <= r_col;
            r_s1_fire   <= win_fits;
            r_s1_last   <= col_end && row_end;
            r_s1_crow   <= POS_W'(r_row - ROW_W'(RADIUS));
            r_s1_ccol   <= POS_W'(r_col - COL_W'(RADIUS));
            r_s1_cidx   <= in_cidx;
            r_s1_cval   <= in_cval;
        end
        if (s1_leave) begin
            r_s2_last <= r_s1_last;
            r_s2_crow <= r_s1_crow;
            r_s2_ccol <= r_s1_ccol;
        end
        if (s2_leave) begin
            r_s3_last <= r_s2_last;
            r_s3_crow <= r_s2_crow;
            r_s3_ccol <= r_s2_ccol;
        end
        if (s3_leave) begin
            r_out_last <= r_s3_last;
            r_out_crow <= r_s3_crow;
            r_out_ccol <= r_s3_ccol;
        end
    end

    // ---------------- line store ----------------
    // Word at column c holds the pixels of the previous K-1 rows at c,
    // slot 0 the row just above. Each pixel reads its column, then writes
    // back the word shifted down by one row with itself in slot 0.
    logic [LB_W-1:0] lb_rdata;
    logic [LB_W-1:0] lb_wdata;

    always_comb begin
        lb_wdata = '0;
        lb_wdata[PIX_W-1:0] = r_s1_pix;
        for (int k = 1; k < KSIZE - 1; k++) begin
            lb_wdata[k*PIX_W +: PIX_W] = lb_rdata[(k-1)*PIX_W +: PIX_W];
        end
    end

    iwc_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_leave && r_s1_is_pix),
        .i_waddr (r_s1_col),
        .i_wdata (lb_wdata),
        .i_re    (s_accept),
        .i_raddr (r_col),
        .o_rdata (lb_rdata)
    );

    // ---------------- window and kernel ----------------
    logic [KAREA-1:0][PIX_W-1:0]  r_win;
    logic [KAREA-1:0][COEF_W-1:0] r_coef;
    t_pix                         new_col [KSIZE];

    always_comb begin
        for (int i = 0; i < KSIZE - 1; i++) begin
            new_col[i] = lb_rdata[(KSIZE-2-i)*PIX_W +: PIX_W];
        end
        new_col[KSIZE-1] = r_s1_pix;
    end

    // window shifts left one column per pixel, new column enters on the right
    always_ff @(posedge i_clk) begin
        if (s1_leave && r_s1_is_pix) begin
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE - 1; j++) begin
                    r_win[i*KSIZE + j] <= r_win[i*KSIZE + j + 1];
                end
                r_win[i*KSIZE + KSIZE - 1] <= new_col[i];
            end
        end
    end

    // coefficients update at the window stage so later pixels see them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (s1_leave && !r_s1_is_pix && (32'(r_s1_cidx) < 32'(KAREA))) begin
            r_coef[r_s1_cidx[KIDX_W-1:0]] <= r_s1_cval;
        end
    end

    // ---------------- multiply and sum ----------------
    t_mac_ctl mac_ctl;
    t_acc     mac_sum;

    assign mac_ctl.prod_en = s2_leave;
    assign mac_ctl.sum_en  = s3_leave;

    iwc_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_win  (r_win),
        .i_coef (r_coef),
        .o_sum  (mac_sum)
    );

    // ---------------- result stream ----------------
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_out_ccol, r_out_crow, mac_sum};

endmodule

// ===== design/iwc_checker.sv =====
`timescale 1ns / 1ps

module iwc_checker import iwc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_we,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_W-1:0]       i_cfg_data,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tlast
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // input back-pressure only comes from a stalled result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output back-pressure");

    // a result after an empty output is preceded by an accepted input
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !$past(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready, 4))
        else $error("result appeared without a preceding input");

endmodule

bind image_window_convolution iwc_checker u_iwc_checker (.*);

// ===== tb/image_window_convolution_tb.sv =====
`timescale 1ns / 1ps

module image_window_convolution_tb import iwc_pkg::*; ();

    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES   = 300;   // long receiver back-pressure stretch
    localparam int SETTLE_CYCLES = 12;    // pipeline is four deep, leave some margin

    // One expected result transaction.
    typedef struct packed {
        t_acc             filtered;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_conv_result;

    // Tracks frame position, kernel and line rows; predicts each window sum.
    class t_conv_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_coef            kernel [KAREA];
        t_pix             rows [KSIZE][MAX_WIDTH];
        int               row_pos;
        int               col_pos;
        t_conv_result     pending_sums [$];
        int               mismatches;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (kernel[i]) kernel[i] = '0;
            foreach (rows[r, c]) rows[r][c] = '0;
            row_pos    = 0;
            col_pos    = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == CFG_IMAGE_WIDTH) width_reg = value;
            else height_reg = value;
            // any write restarts the frame
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void accept_item(logic op, logic [CIDX_W-1:0] idx, t_coef cval, t_pix pix);
            int           w;
            int           h;
            int           r;
            int           c;
            longint       acc;
            t_conv_result res;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : int'(height_reg);
            if (op == OP_COEF) begin
                // out-of-range kernel positions are dropped
                if (idx < KAREA) kernel[idx] = cval;
                return;
            end
            if (col_pos >= w) col_pos = 0;
            if (row_pos >= h) row_pos = 0;
            r = row_pos;
            c = col_pos;
            rows[r % KSIZE][c] = pix;
            if (r >= KSIZE - 1 && c >= KSIZE - 1) begin
                acc = 0;
                for (int i = 0; i < KSIZE; i++) begin
                    for (int j = 0; j < KSIZE; j++) begin
                        acc += longint'(rows[(r - KSIZE + 1 + i) % KSIZE][c - KSIZE + 1 + j])
                               * longint'(kernel[i * KSIZE + j]);
                    end
                end
                res.filtered = t_acc'(acc);
                res.row      = POS_W'(r - RADIUS);
                res.col      = POS_W'(c - RADIUS);
                res.last     = (r == h - 1) && (c == w - 1);
                pending_sums.push_back(res);
            end
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            t_conv_result exp_res;
            t_conv_result got;
            if (pending_sums.size() == 0) begin
                $error("result transaction with nothing expected: tdata %h", tdata);
                mismatches++;
                return;
            end
            exp_res      = pending_sums.pop_front();
            got.filtered = tdata[ACC_W-1:0];
            got.row      = tdata[ACC_W +: POS_W];
            got.col      = tdata[ACC_W + POS_W +: POS_W];
            got.last     = tlast;
            if (got.filtered !== exp_res.filtered) begin
                $error("filtered: expected %0d, actual %0d", exp_res.filtered, got.filtered);
                mismatches++;
            end
            if (got.row !== exp_res.row) begin
                $error("centre_row: expected %0d, actual %0d", exp_res.row, got.row);
                mismatches++;
            end
            if (got.col !== exp_res.col) begin
                $error("centre_col: expected %0d, actual %0d", exp_res.col, got.col);
                mismatches++;
            end
            if (got.last !== exp_res.last) begin
                $error("frame_last: expected %0b, actual %0b", exp_res.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // coef_index, coef_value, pixel, zero pad
    logic                   i_s_axis_tuser;   // opcode
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // filtered, centre_row, centre_col, zero pad
    logic                   o_m_axis_tlast;   // frame_last

    t_conv_scoreboard sb;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               hold_request;

    image_window_convolution u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
    end

    // Watchdog: too long with no transaction on either stream means a hang.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Register write; only called while the block is idle.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] index, int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        sb.write_reg(index, CFG_W'(value));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one input item (after random idle cycles) and wait for the transaction.
    task automatic send_item(logic op, logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] cval,
                             t_pix pix);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= IN_TDATA_W'({pix, cval, idx});
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.accept_item(op, idx, t_coef'(cval), pix);
    endtask

    // Mostly pixels; some coefficient loads, a share of them out of range.
    task automatic send_random_item();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            send_item(OP_COEF,
                      (roll < 8) ? CIDX_W'($urandom_range(KAREA - 1))
                                 : CIDX_W'($urandom_range(63, KAREA)),
                      COEF_W'($urandom), PIX_W'($urandom));
        end else begin
            send_item(OP_PIXEL, CIDX_W'($urandom), COEF_W'($urandom),
                      (roll < 13) ? 16'hFFFF : (roll < 16) ? 16'h0000 : PIX_W'($urandom));
        end
    endtask

    // Drop valid, let every expected result arrive, then let the pipe empty.
    task automatic drain_block();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int n, int s_pct, int r_pct, bit hold);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < n; k++) begin
            // long output stall while the sender keeps pushing
            if (hold && k == 30) hold_request = 1'b1;
            send_random_item();
        end
        drain_block();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_COEF;
        send_idle_pct   = 14;
        recv_idle_pct   = 74;
        hold_request    = 1'b0;
        sb              = new();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest frame, kernel extremes, dropped indexes, mid-frame load.
        cfg_write(CFG_IMAGE_WIDTH, 3);
        cfg_write(CFG_IMAGE_HEIGHT, 3);
        send_item(OP_COEF, CIDX_W'(0), 16'h8000, 16'hFFFF);
        for (int k = 1; k < KAREA - 1; k++)
            send_item(OP_COEF, CIDX_W'(k), COEF_W'($urandom), PIX_W'($urandom));
        send_item(OP_COEF, CIDX_W'(KAREA), 16'h1234, 16'hFFFF);   // just past the kernel
        send_item(OP_COEF, 6'h3F, 16'hFFFF, 16'h0000);            // top index
        for (int k = 0; k < KAREA; k++) begin
            // last coefficient arrives mid-frame, before the window completes
            if (k == 5) send_item(OP_COEF, CIDX_W'(KAREA - 1), 16'h7FFF, 16'h0000);
            send_item(OP_PIXEL, CIDX_W'($urandom), COEF_W'($urandom),
                      (k == 4) ? 16'h0000 : 16'hFFFF);
        end
        drain_block();

        // Sender mostly busy, receiver mostly stalling
        run_phase(3, 3, 60, 14, 74, 1'b0);
        run_phase(0, 5, 30, 14, 74, 1'b0);       // width clamps to 1: no windows
        run_phase(7, 5, 120, 14, 74, 1'b0);
        run_phase(4, 2047, 100, 14, 74, 1'b0);   // height clamps to the maximum

        // Sender mostly idle, receiver mostly ready
        run_phase(2, 9, 40, 74, 14, 1'b0);       // narrower than the kernel
        run_phase(9, 2, 40, 74, 14, 1'b0);       // lower than the kernel
        run_phase($urandom_range(12, 3), $urandom_range(12, 3), 120, 74, 14, 1'b0);
        run_phase($urandom_range(12, 3), $urandom_range(12, 3), 120, 74, 14, 1'b0);

        // No idling
        run_phase(8, 40, 300, 0, 0, 1'b1);
        run_phase(2047, 3, 150, 0, 0, 1'b0);     // width clamps to 1024
        run_phase(3, 1024, 100, 0, 0, 1'b0);
        run_phase($urandom_range(12, 3), $urandom_range(12, 3), 80, 0, 0, 1'b0);
        run_phase(3, 0, 20, 0, 0, 1'b0);         // height clamps to 1

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
